// File: rtl/gspd_pkg.sv
// gspd_pkg: types, fixed-point gain constants and band thresholds for the
// gain scheduled pd steering block
// no dependencies
`default_nettype none

package gspd_pkg;

    // widths of the datapath
    localparam int OFF_W  = 10;  // signed offset
    localparam int SPD_W  = 10;  // unsigned target speed
    localparam int VAL_W  = 16;  // steering value and config registers
    localparam int KP_W   = 17;  // unsigned q5.12 proportional gain
    localparam int KD_W   = 4;   // integer derivative gain
    localparam int FRAC_W = 12;  // fraction bits of the gains
    localparam int ACC_W  = 32;  // signed q.12 sum
    localparam int MC_W   = 27;  // shifted multiplicand (3*kp shifted by up to 8)
    localparam int DIG_N  = 5;   // radix-4 digits of the offset magnitude

    localparam int Q_ONE = 4096;

    // q.12 slopes, rounded to nearest step
    localparam logic [11:0] SLOPE_P1 = 12'd410;
    localparam logic [11:0] SLOPE_P2 = 12'd819;
    localparam logic [11:0] SLOPE_P5 = 12'd2048;
    localparam logic [11:0] SLOPE_P6 = 12'd2458;
    localparam logic [4:0]  QUAD_POS = 5'd27;
    localparam logic [4:0]  QUAD_NEG = 5'd20;

    // speed band boundaries
    localparam logic [SPD_W-1:0] SPD_B1 = 10'd100;
    localparam logic [SPD_W-1:0] SPD_B2 = 10'd159;
    localparam logic [SPD_W-1:0] SPD_B3 = 10'd280;
    localparam logic [SPD_W-1:0] SPD_B4 = 10'd300;
    localparam logic [SPD_W-1:0] SPD_B5 = 10'd310;

    // configuration register indexes
    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_LEFT   = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;

    typedef enum logic [2:0] {
        BAND_SLOW,   // below 100, fixed kp
        BAND_LOW,    // below 159, piecewise linear
        BAND_MID,    // below 280, sign dependent quadratic
        BAND_HIGH,   // below 300
        BAND_FAST,   // below 310
        BAND_TOP     // everything above
    } band_t;

    // q.12 multiple of one as a kp value
    function automatic logic [KP_W-1:0] kp_units(input int n);
        return KP_W'(n * Q_ONE);
    endfunction

    // linear segment: t * slope + base, t below 20 inside a segment
    function automatic logic [KP_W-1:0] lin_seg(input logic [5:0] t,
                                                input logic [11:0] slope,
                                                input logic [KP_W-1:0] base);
        logic [17:0] prod;
        prod = {12'b0, t} * {6'b0, slope};
        return prod[KP_W-1:0] + base;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gain_scheduled_pd_steering.sv
// gain_scheduled_pd_steering: speed banded pd steering law with clamp and
// hold averaging, radix-4 digit serial kp*offset product
// depends on gspd_pkg
// flow: an input transaction is taken in the idle state, then a normal item
//   passes the two gain states, the 5 radix-4 digit steps of the kp*offset
//   multiply, a clamp state and the send state that moves it into the output
//   register; a hold item goes from idle straight to the send state; one item
//   in flight, and the send state waits while m_tready stalls a full output register
// reset: aresetn synchronous active low; registers back to center 3510,
//   left 3900, right 3120, offset and output history cleared
`default_nettype none

module gain_scheduled_pd_steering (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    // input channel
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [23:0] s_tdata,   // [9:0] offset, [19:10] target_speed, rest zero
    input  wire logic        s_tuser,   // [0] hold
    // result channel
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata    // [15:0] steer_value
);

    localparam int OW = gspd_pkg::OFF_W;
    localparam int VW = gspd_pkg::VAL_W;
    localparam int KW = gspd_pkg::KP_W;
    localparam int AW = gspd_pkg::ACC_W;
    localparam int MW = gspd_pkg::MC_W;
    localparam int FRAC_SH = gspd_pkg::FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for an input transaction
        ST_GAIN1,   // band, abs offset, kd, offset delta
        ST_GAIN2,   // kp and accumulator seed
        ST_MUL,     // one radix-4 digit of kp*|offset| per cycle
        ST_CLAMP,   // truncate and clamp
        ST_SEND     // move result into the output register
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [VW-1:0] center_reg, center_next;
    logic [VW-1:0] left_reg, left_next;
    logic [VW-1:0] right_reg, right_next;

    // history
    logic signed [OW-1:0] prev_off_reg, prev_off_next;
    logic [VW-1:0] p1_reg, p1_next;
    logic [VW-1:0] p2_reg, p2_next;

    // item being worked on
    logic signed [OW-1:0] off_reg, off_next;
    logic [gspd_pkg::SPD_W-1:0] spd_reg, spd_next;
    gspd_pkg::band_t band_reg, band_next;
    logic [OW-1:0] a_reg, a_next;          // |offset|
    logic [OW-1:0] mag_reg, mag_next;      // digit shift register of |offset|
    logic pos_reg, pos_next;               // offset > 0
    logic neg_reg, neg_next;               // offset < 0
    logic [9:0] dsq_reg, dsq_next;         // (|offset| - 30)^2, low 5 bits of delta
    logic [gspd_pkg::KD_W-1:0] kd_reg, kd_next;
    logic signed [OW:0] diff_reg, diff_next;
    logic [MW-1:0] m1_reg, m1_next;        // kp shifted by 2 per digit
    logic [MW-1:0] m3_reg, m3_next;        // 3*kp shifted by 2 per digit
    logic signed [AW-1:0] acc_reg, acc_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [VW-1:0] res_reg, res_next;

    // output register
    logic m_tvalid_reg, m_tvalid_next;
    logic [VW-1:0] m_tdata_reg, m_tdata_next;

    // combinational helpers
    logic signed [OW-1:0] in_off;
    logic [gspd_pkg::SPD_W-1:0] in_spd;
    logic [VW:0] avg_sum;
    logic [OW-1:0] abs_off;
    logic [OW-1:0] d30;
    logic [5:0] t25, t35, t45;
    logic [KW-1:0] kp;
    logic [KW-1:0] quad_base;
    logic [14:0] quad_prod;
    logic [KW+1:0] kp3;
    logic signed [15:0] dterm;
    logic signed [17:0] seed;
    logic [MW-1:0] term;
    logic signed [AW-FRAC_SH-1:0] quo;
    logic signed [AW-FRAC_SH-1:0] quo_fix;
    logic [VW-1:0] clamped;

    assign in_off  = s_tdata[OW-1:0];
    assign in_spd  = s_tdata[OW+gspd_pkg::SPD_W-1:OW];
    assign avg_sum = {1'b0, p1_reg} + {1'b0, p2_reg};

    // gain stage 1 helpers
    assign abs_off = off_reg[OW-1] ? OW'(-off_reg) : off_reg;
    assign d30     = abs_off - OW'(30);

    // gain stage 2: kp selection from band and |offset|
    assign t25 = 6'(a_reg - OW'(25));
    assign t35 = 6'(a_reg - OW'(35));
    assign t45 = 6'(a_reg - OW'(45));
    assign quad_base = pos_reg ? gspd_pkg::kp_units(3) : gspd_pkg::kp_units(2);
    assign quad_prod = {5'b0, dsq_reg} * {10'b0, (pos_reg ? gspd_pkg::QUAD_POS
                                                          : gspd_pkg::QUAD_NEG)};

    always_comb begin
        kp = gspd_pkg::kp_units(8);
        case (band_reg)
            gspd_pkg::BAND_SLOW: begin
                kp = gspd_pkg::kp_units(8);
            end
            gspd_pkg::BAND_LOW: begin
                if (a_reg < OW'(25))      kp = gspd_pkg::kp_units(2);
                else if (a_reg < OW'(45)) kp = gspd_pkg::lin_seg(t25, gspd_pkg::SLOPE_P1,
                                                                 gspd_pkg::kp_units(2));
                else if (a_reg < OW'(55)) kp = gspd_pkg::lin_seg(t35, gspd_pkg::SLOPE_P2,
                                                                 gspd_pkg::kp_units(4));
                else if (a_reg < OW'(65)) kp = gspd_pkg::lin_seg(t45, gspd_pkg::SLOPE_P1,
                                                                 gspd_pkg::kp_units(6));
                else                      kp = gspd_pkg::kp_units(8);
            end
            gspd_pkg::BAND_MID: begin
                if (a_reg < OW'(30))      kp = quad_base;
                else if (a_reg < OW'(60)) kp = {2'b0, quad_prod} + quad_base;
                else                      kp = gspd_pkg::kp_units(10);
            end
            gspd_pkg::BAND_HIGH: begin
                if (a_reg < OW'(25))      kp = gspd_pkg::kp_units(4);
                else if (a_reg < OW'(35)) kp = gspd_pkg::lin_seg(t25, gspd_pkg::SLOPE_P5,
                                                                 gspd_pkg::kp_units(4));
                else if (a_reg < OW'(45)) kp = gspd_pkg::lin_seg(t35, gspd_pkg::SLOPE_P6,
                                                                 gspd_pkg::kp_units(9));
                else if (a_reg < OW'(55)) kp = gspd_pkg::lin_seg(t45, gspd_pkg::SLOPE_P1,
                                                                 gspd_pkg::kp_units(15));
                else                      kp = gspd_pkg::kp_units(16);
            end
            default: begin
                // fast and top bands share kp
                if (a_reg < OW'(25))      kp = gspd_pkg::kp_units(6);
                else if (a_reg < OW'(35)) kp = gspd_pkg::lin_seg(t25, gspd_pkg::SLOPE_P2,
                                                                 gspd_pkg::kp_units(6));
                else if (a_reg < OW'(45)) kp = gspd_pkg::lin_seg(t35, gspd_pkg::SLOPE_P6,
                                                                 gspd_pkg::kp_units(8));
                else if (a_reg < OW'(55)) kp = gspd_pkg::lin_seg(t45, gspd_pkg::SLOPE_P2,
                                                                 gspd_pkg::kp_units(14));
                else                      kp = gspd_pkg::kp_units(16);
            end
        endcase
    end

    assign kp3 = {2'b0, kp} + {1'b0, kp, 1'b0};

    // derivative term and accumulator seed: (center - kd*delta) in integer units
    assign dterm = $signed({1'b0, kd_reg}) * diff_reg;
    assign seed  = $signed({2'b0, center_reg}) - 18'(dterm);

    // current radix-4 digit of |offset| selects 0, kp, 2kp or 3kp
    always_comb begin
        case (mag_reg[1:0])
            2'd0:    term = '0;
            2'd1:    term = m1_reg;
            2'd2:    term = {m1_reg[MW-2:0], 1'b0};
            default: term = m3_reg;
        endcase
    end

    // truncation toward zero of the q.12 sum, then clamp
    assign quo     = acc_reg[AW-1:FRAC_SH];
    assign quo_fix = (acc_reg[AW-1] && (acc_reg[FRAC_SH-1:0] != '0)) ? quo + 1'b1 : quo;

    always_comb begin
        if (quo_fix > $signed({{(AW-FRAC_SH-VW){1'b0}}, left_reg})) begin
            clamped = left_reg;
        end else if (quo_fix < $signed({{(AW-FRAC_SH-VW){1'b0}}, right_reg})) begin
            clamped = right_reg;
        end else begin
            clamped = quo_fix[VW-1:0];
        end
    end

    // next state and datapath
    always_comb begin
        state_next    = state_reg;
        center_next   = center_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        prev_off_next = prev_off_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        off_next      = off_reg;
        spd_next      = spd_reg;
        band_next     = band_reg;
        a_next        = a_reg;
        mag_next      = mag_reg;
        pos_next      = pos_reg;
        neg_next      = neg_reg;
        dsq_next      = dsq_reg;
        kd_next       = kd_reg;
        diff_next     = diff_reg;
        m1_next       = m1_reg;
        m3_next       = m3_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        // configuration writes
        if (cfg_we) begin
            unique case (cfg_index)
                gspd_pkg::REG_CENTER: center_next = cfg_data;
                gspd_pkg::REG_LEFT:   left_next   = cfg_data;
                gspd_pkg::REG_RIGHT:  right_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        // bad measurement: mean of the last two results
                        res_next   = avg_sum[VW:1];
                        p2_next    = p1_reg;
                        p1_next    = avg_sum[VW:1];
                        state_next = ST_SEND;
                    end else begin
                        off_next   = in_off;
                        spd_next   = in_spd;
                        state_next = ST_GAIN1;
                    end
                end
            end
            ST_GAIN1: begin
                if (spd_reg < gspd_pkg::SPD_B1)      band_next = gspd_pkg::BAND_SLOW;
                else if (spd_reg < gspd_pkg::SPD_B2) band_next = gspd_pkg::BAND_LOW;
                else if (spd_reg < gspd_pkg::SPD_B3) band_next = gspd_pkg::BAND_MID;
                else if (spd_reg < gspd_pkg::SPD_B4) band_next = gspd_pkg::BAND_HIGH;
                else if (spd_reg < gspd_pkg::SPD_B5) band_next = gspd_pkg::BAND_FAST;
                else                                 band_next = gspd_pkg::BAND_TOP;

                if (spd_reg < gspd_pkg::SPD_B1) begin
                    kd_next = 4'd0;
                end else if (spd_reg < gspd_pkg::SPD_B2) begin
                    kd_next = 4'd5;
                end else if (spd_reg < gspd_pkg::SPD_B3) begin
                    kd_next = (abs_off >= OW'(30) && abs_off < OW'(60)) ? 4'd15 : 4'd12;
                end else if (spd_reg < gspd_pkg::SPD_B4) begin
                    kd_next = 4'd5;
                end else if (spd_reg < gspd_pkg::SPD_B5) begin
                    kd_next = 4'd3;
                end else begin
                    kd_next = 4'd5;
                end

                a_next        = abs_off;
                mag_next      = abs_off;
                pos_next      = !off_reg[OW-1] && (off_reg != '0);
                neg_next      = off_reg[OW-1];
                dsq_next      = {5'b0, d30[4:0]} * {5'b0, d30[4:0]};
                diff_next     = {off_reg[OW-1], off_reg} - {prev_off_reg[OW-1], prev_off_reg};
                prev_off_next = off_reg;
                state_next    = ST_GAIN2;
            end
            ST_GAIN2: begin
                m1_next    = {{(MW-KW){1'b0}}, kp};
                m3_next    = {{(MW-KW-2){1'b0}}, kp3};
                acc_next   = {{(AW-18-FRAC_SH){seed[17]}}, seed, {FRAC_SH{1'b0}}};
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                // offset negative: -kp*offset adds the magnitude product
                if (neg_reg) acc_next = acc_reg + $signed({{(AW-MW){1'b0}}, term});
                else         acc_next = acc_reg - $signed({{(AW-MW){1'b0}}, term});
                mag_next = {2'b0, mag_reg[OW-1:2]};
                m1_next  = {m1_reg[MW-3:0], 2'b0};
                m3_next  = {m3_reg[MW-3:0], 2'b0};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(gspd_pkg::DIG_N - 1)) begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                res_next   = clamped;
                p2_next    = p1_reg;
                p1_next    = clamped;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                // output register free or being drained this cycle
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            center_reg   <= 16'd3510;
            left_reg     <= 16'd3900;
            right_reg    <= 16'd3120;
            prev_off_reg <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            center_reg   <= center_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            prev_off_reg <= prev_off_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
        // payload, no reset needed
        off_reg     <= off_next;
        spd_reg     <= spd_next;
        band_reg    <= band_next;
        a_reg       <= a_next;
        mag_reg     <= mag_next;
        pos_reg     <= pos_next;
        neg_reg     <= neg_next;
        dsq_reg     <= dsq_next;
        kd_reg      <= kd_next;
        diff_reg    <= diff_next;
        m1_reg      <= m1_next;
        m3_reg      <= m3_next;
        acc_reg     <= acc_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
